FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the tab expander RTL.
// Expects clk and rst (synchronous, active high) in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is high.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLY(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

FILE: rtl/core/ttse_pkg.sv
// Package for the tab-to-space expander: register indexes, byte codes,
// state encoding and the control structs. No dependencies.
`default_nettype none

package ttse_pkg;

  localparam int MAP_BITS    = 256;
  localparam int MAP_IDX_W   = 8;
  localparam int WORD_BITS   = 64;
  localparam int CHUNK_BITS  = 8;
  localparam int CHUNK_SHIFT = 3;
  localparam int CFG_INDEX_W = 3;

  localparam logic [7:0] NEWLINE_BYTE    = 8'h0A;
  localparam logic [7:0] SPACE_BYTE      = 8'h20;
  localparam logic [7:0] TAB_CHAR_RESET  = 8'h09;
  localparam logic [7:0] TAB_WIDTH_RESET = 8'd8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TAB_CHARACTER = 3'd0,
    REG_LIST_MODE     = 3'd1,
    REG_TAB_WIDTH     = 3'd2,
    REG_STOPS_0       = 3'd3,
    REG_STOPS_1       = 3'd4,
    REG_STOPS_2       = 3'd5,
    REG_STOPS_3       = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0]          tab_character;
    logic                list_mode;
    logic [7:0]          tab_width;
    logic [MAP_BITS-1:0] stop_map;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic tab_now;
    logic calc_done;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/tab_to_space_expander.sv
// Top level of the tab-to-space expander: register bank, controller, datapath.
// Depends on ttse_pkg, ttse_cfg, ttse_ctrl and ttse_dp.
//
// Usage:
//   Input channel (in_valid/in_ready/in_byte) takes one text byte per
//   transaction. Output channel (out_valid/out_ready/out_byte/repeat_count)
//   returns one result per input: the byte, or a space for a tab, and how
//   many times to emit it. Config channel (cfg_valid/cfg_ready/cfg_index/
//   cfg_data) writes the registers; cfg_ready is always high. Write config
//   only while no byte is in flight.
// Sequencing:
//   Plain byte or newline: accepted in idle, result loaded in emit.
//   Tab, uniform mode: bit-serial column remainder in calc, then emit.
//   Tab, list mode: stop search in calc (8 stop bits per cycle), then emit.
//   The next byte is accepted in the cycle after a result is loaded, so a
//   new byte is taken only once the last one's result is loaded.
// Reset: rst clears the column to 1, registers to their defaults, output
//   empty. Stall: a result waits in the output register; one more byte is
//   taken and processed, then the block holds until out_ready frees the slot.
`default_nettype none

module tab_to_space_expander #(
  parameter int STOP_COLUMNS = 256,
  parameter int COLUMN_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_byte,
  output logic [7:0]                       repeat_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ttse_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ttse_pkg::WORD_BITS-1:0]   cfg_data
);
  import ttse_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // register bank
  ttse_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencing: accept, iterate, emit
  ttse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // column tracking, remainder and stop search, result register
  ttse_dp #(
    .STOP_COLUMNS (STOP_COLUMNS),
    .COLUMN_BITS  (COLUMN_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_byte      (in_byte),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .out_byte     (out_byte),
    .repeat_count (repeat_count)
  );

endmodule

`default_nettype wire

FILE: rtl/core/ttse_cfg.sv
// Configuration register bank of the tab expander.
// Depends on ttse_pkg.
`default_nettype none

module ttse_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ttse_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ttse_pkg::WORD_BITS-1:0]   cfg_data,
  output ttse_pkg::cfg_t                   cfg
);
  import ttse_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tab_character <= TAB_CHAR_RESET;
      cfg.list_mode     <= 1'b0;
      cfg.tab_width     <= TAB_WIDTH_RESET;
      cfg.stop_map      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TAB_CHARACTER: cfg.tab_character <= cfg_data[7:0];
        REG_LIST_MODE:     cfg.list_mode     <= cfg_data[0];
        REG_TAB_WIDTH:     cfg.tab_width     <= cfg_data[7:0];
        REG_STOPS_0:       cfg.stop_map[0*WORD_BITS +: WORD_BITS] <= cfg_data;
        REG_STOPS_1:       cfg.stop_map[1*WORD_BITS +: WORD_BITS] <= cfg_data;
        REG_STOPS_2:       cfg.stop_map[2*WORD_BITS +: WORD_BITS] <= cfg_data;
        REG_STOPS_3:       cfg.stop_map[3*WORD_BITS +: WORD_BITS] <= cfg_data;
        default: ;  // drop writes past the register list
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ttse_ctrl.sv
// Controller state machine of the tab expander: handshakes and sequencing.
// Depends on ttse_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ttse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ttse_pkg::status_t status,
  output ttse_pkg::cmd_t    cmd
);
  import ttse_pkg::*;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.tab_now ? ST_CALC : ST_EMIT;
        end
      end
      ST_CALC: begin
        if (status.calc_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CALC: cmd.step = !status.calc_done;
      ST_EMIT: cmd.emit = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_IMPLY(a_emit_needs_slot, cmd.emit, !out_valid || out_ready, "emit over a pending result")
  `ASSERT_CLK(a_plain_goes_emit, (state == ST_IDLE && in_valid && !status.tab_now) |=> (state == ST_EMIT), "plain byte did not go to emit")
  `ASSERT_CLK(a_emit_shows_result, cmd.emit |=> out_valid, "emitted result not presented")

endmodule

`default_nettype wire

FILE: rtl/core/ttse_dp.sv
// Datapath of the tab expander: column counter, bit-serial remainder unit,
// chunked stop search and the result register. Depends on ttse_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ttse_dp #(
  parameter int STOP_COLUMNS = 256,
  parameter int COLUMN_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        in_byte,
  input  ttse_pkg::cfg_t    cfg,
  input  ttse_pkg::cmd_t    cmd,
  output ttse_pkg::status_t status,
  output logic [7:0]        out_byte,
  output logic [7:0]        repeat_count
);
  import ttse_pkg::*;

  localparam int CHUNKS = (STOP_COLUMNS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int IDX_W  = $clog2(CHUNKS);
  localparam int CNT_W  = $clog2(COLUMN_BITS + 1);
  localparam logic [IDX_W-1:0] LAST_CHUNK = IDX_W'(CHUNKS - 1);

  logic [COLUMN_BITS-1:0] column;
  logic [7:0]             byte_q;
  logic                   nl_q;
  logic                   tab_q;
  logic [7:0]             rem;
  logic [COLUMN_BITS-1:0] sh;
  logic [CNT_W-1:0]       cnt;
  logic [IDX_W-1:0]       scan_idx;
  logic [7:0]             run;
  logic                   done;

  logic                   is_nl;
  logic                   is_tab;
  logic [7:0]             divisor;
  logic [COLUMN_BITS:0]   col_p1;
  logic                   beyond;
  logic [8:0]             rem_sh;
  logic [7:0]             rem_next;
  logic [MAP_IDX_W-1:0]   base;
  logic [CHUNK_BITS-1:0]  chunk;
  logic [CHUNK_BITS-1:0]  cand;
  logic                   hit;
  logic [MAP_IDX_W-1:0]   hit_k;
  logic [MAP_IDX_W-1:0]   kval;
  logic [7:0]             count_sel;
  logic [COLUMN_BITS:0]   sum;
  logic [COLUMN_BITS-1:0] col_adv;

  assign is_nl   = (in_byte == NEWLINE_BYTE);
  assign is_tab  = !is_nl && (in_byte == cfg.tab_character);
  assign divisor = (cfg.tab_width == 8'd0) ? 8'd1 : cfg.tab_width;
  assign col_p1  = {1'b0, column} + (COLUMN_BITS + 1)'(1);
  assign beyond  = (col_p1 >= (COLUMN_BITS + 1)'(STOP_COLUMNS));

  // one restoring step: remainder stays below the divisor
  assign rem_sh   = {rem, sh[COLUMN_BITS-1]};
  assign rem_next = (rem_sh >= {1'b0, divisor}) ? 8'(rem_sh - {1'b0, divisor}) : rem_sh[7:0];

  assign base  = MAP_IDX_W'(scan_idx) << CHUNK_SHIFT;
  assign chunk = cfg.stop_map[base +: CHUNK_BITS];

  always_comb begin
    cand  = '0;
    hit_k = '0;
    kval  = '0;
    for (int j = 0; j < CHUNK_BITS; j++) begin
      kval = base + MAP_IDX_W'(j);
      cand[j] = chunk[j] && ((MAP_IDX_W + 1)'(kval) < (MAP_IDX_W + 1)'(STOP_COLUMNS))
                && (COLUMN_BITS'(kval) > column);
    end
    for (int j = CHUNK_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        hit_k = base + MAP_IDX_W'(j);
      end
    end
  end
  assign hit = |cand;

  assign count_sel = tab_q ? (cfg.list_mode ? run : 8'(divisor - rem)) : 8'd1;
  assign sum       = {1'b0, column} + (COLUMN_BITS + 1)'(count_sel);
  assign col_adv   = sum[COLUMN_BITS] ? '1 : sum[COLUMN_BITS-1:0];

  assign status.tab_now   = is_tab;
  assign status.calc_done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= COLUMN_BITS'(1);
      done   <= 1'b0;
    end else begin
      if (cmd.load) begin
        done <= cfg.list_mode && beyond;
      end else if (cmd.step) begin
        if (cfg.list_mode) begin
          if (hit || scan_idx == LAST_CHUNK) begin
            done <= 1'b1;
          end
        end else if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
      if (cmd.emit) begin
        column <= nl_q ? COLUMN_BITS'(1) : col_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_q   <= in_byte;
      nl_q     <= is_nl;
      tab_q    <= is_tab;
      rem      <= '0;
      sh       <= column;
      cnt      <= CNT_W'(COLUMN_BITS);
      scan_idx <= col_p1[CHUNK_SHIFT +: IDX_W];
      run      <= 8'd1;
    end else if (cmd.step) begin
      if (cfg.list_mode) begin
        if (hit) begin
          run <= 8'(hit_k) - column[7:0];
        end else if (scan_idx != LAST_CHUNK) begin
          scan_idx <= scan_idx + IDX_W'(1);
        end
      end else begin
        rem <= rem_next;
        sh  <= sh << 1;
        cnt <= cnt - CNT_W'(1);
      end
    end
    if (cmd.emit) begin
      out_byte     <= tab_q ? SPACE_BYTE : byte_q;
      repeat_count <= count_sel;
    end
  end

  `ASSERT_CLK(a_rem_below_divisor, (cmd.step && !cfg.list_mode) |=> (rem < divisor), "remainder not below divisor")
  `ASSERT_IMPLY(a_column_nonzero, 1'b1, column != '0, "column left the 1-based range")
  `ASSERT_IMPLY(a_count_nonzero, cmd.emit, count_sel != 8'd0, "zero repeat count emitted")

endmodule

`default_nettype wire

FILE: bench/tab_to_space_expander_tb.sv
// Self-checking testbench for tab_to_space_expander: directed table, then random phases.
// Depends on ttse_pkg and the tab_to_space_expander RTL only.
`timescale 1ns / 100ps

module tab_to_space_expander_tb;
  import ttse_pkg::*;

  localparam int          STOP_COLS = 256;
  localparam int          COL_BITS  = 16;
  localparam int unsigned COL_MAX   = (1 << COL_BITS) - 1;
  // Index 7 maps to no register; writes to it must change nothing.
  localparam logic [2:0]  REG_NONE  = 3'd7;

  // One emitted run: a byte and how many times it repeats.
  typedef struct packed {
    logic [7:0] chr;
    logic [7:0] reps;
  } run_t;

  typedef enum logic {ROW_WRITE, ROW_TEXT} row_kind_e;

  // One step of the directed plan: a register write or a text byte,
  // optionally with the run typed in by hand.
  typedef struct packed {
    row_kind_e  kind;
    logic [2:0] idx;
    logic [63:0] data;
    logic [7:0] text;
    logic       known;
    run_t       want;
  } plan_row_t;

  logic        clk;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte      = 8'h00;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [7:0]  out_byte;
  logic [7:0]  repeat_count;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index    = 3'd0;
  logic [63:0] cfg_data     = 64'd0;

  // Predictor copy of the register bank and the column.
  logic [7:0]   cur_tab_char;
  logic         cur_list_mode;
  logic [7:0]   cur_tab_width;
  logic [255:0] cur_stops;
  int unsigned  col_now;

  run_t      pending_runs[$];
  plan_row_t plan[$];

  // Random shaping knobs, set per phase.
  int tab_pct;
  int nl_permille;
  int src_calm;
  int sink_calm;
  int sink_gap;

  // Bookkeeping for the report at the end.
  int bytes_sent;
  int runs_checked;
  int miss_count;
  int tabs_uniform;
  int tabs_list;
  int sat_hits;
  run_t got_want;

  tab_to_space_expander #(
    .STOP_COLUMNS (STOP_COLS),
    .COLUMN_BITS  (COL_BITS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .repeat_count (repeat_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs; well above the slowest legal run.
  initial begin
    #(5_000_000);
    $display("Verification failed");
    $finish;
  end

  // Draw the idle cycles before the next transaction on one side. Now and then
  // enter a calm stretch where that side does not idle at all.
  function automatic int draw_gap(input bit sink_side);
    int calm;
    int gap;
    calm = sink_side ? sink_calm : src_calm;
    gap  = 0;
    if (calm > 0) begin
      calm--;
    end else if ($urandom_range(0, 23) == 0) begin
      calm = $urandom_range(8, 40);
    end else begin
      gap = $urandom_range(0, 4);
    end
    if (sink_side) sink_calm = calm;
    else src_calm = calm;
    return gap;
  endfunction

  function automatic void reset_model();
    cur_tab_char  = TAB_CHAR_RESET;
    cur_list_mode = 1'b0;
    cur_tab_width = TAB_WIDTH_RESET;
    cur_stops     = '0;
    col_now       = 1;
  endfunction

  // Mirror a register write; narrow registers keep their low bits only.
  function automatic void store_reg(input logic [2:0] idx, input logic [63:0] data);
    case (idx)
      REG_TAB_CHARACTER: cur_tab_char       = data[7:0];
      REG_LIST_MODE:     cur_list_mode      = data[0];
      REG_TAB_WIDTH:     cur_tab_width      = data[7:0];
      REG_STOPS_0:       cur_stops[63:0]    = data;
      REG_STOPS_1:       cur_stops[127:64]  = data;
      REG_STOPS_2:       cur_stops[191:128] = data;
      REG_STOPS_3:       cur_stops[255:192] = data;
      default: ;
    endcase
  endfunction

  // Predict the run for one text byte and advance the column.
  function automatic run_t expand_byte(input logic [7:0] b);
    run_t        r;
    int unsigned run;
    int unsigned n;
    int unsigned k;
    bit          found;
    r.chr = b;
    run   = 1;
    if (b == NEWLINE_BYTE) begin
      // newline wins even when it is also the configured tab byte
      col_now = 1;
    end else begin
      if (b == cur_tab_char) begin
        r.chr = SPACE_BYTE;
        if (cur_list_mode) begin
          // scan forward for the next stop; none left means a single space
          found = 1'b0;
          k     = col_now + 1;
          while (!found && k < STOP_COLS) begin
            if (cur_stops[k]) found = 1'b1;
            else k++;
          end
          run = found ? k - col_now : 1;
          tabs_list++;
        end else begin
          n   = (cur_tab_width == 8'd0) ? 32'd1 : 32'(cur_tab_width);
          run = n - (col_now % n);
          tabs_uniform++;
        end
      end
      if (col_now + run > COL_MAX) begin
        col_now = COL_MAX;
        sat_hits++;
      end else begin
        col_now = col_now + run;
      end
    end
    r.reps = run[7:0];
    return r;
  endfunction

  function automatic logic [63:0] rand_word(input int thin);
    logic [63:0] w;
    w = '1;
    repeat (thin) w &= {$urandom, $urandom};
    return w;
  endfunction

  // Random filler above the bits a narrow register keeps.
  function automatic logic [63:0] with_junk(input logic [63:0] v, input logic [63:0] keep);
    return ({$urandom, $urandom} & ~keep) | (v & keep);
  endfunction

  // Pick the next text byte with the current phase's mix of tabs and newlines.
  function automatic logic [7:0] pick_text();
    logic [7:0] b;
    if ($urandom_range(0, 99) < tab_pct) begin
      b = cur_tab_char;
    end else if ($urandom_range(0, 999) < nl_permille) begin
      b = NEWLINE_BYTE;
    end else begin
      b = 8'($urandom_range(0, 255));
      // keep long lines unbroken when the phase asks for no newlines
      if (b == NEWLINE_BYTE && nl_permille == 0) b = SPACE_BYTE;
    end
    return b;
  endfunction

  function automatic void add_write(input logic [2:0] idx, input logic [63:0] data);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_WRITE;
    row.idx  = idx;
    row.data = data;
    plan.push_back(row);
  endfunction

  function automatic void add_text(input logic [7:0] b);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_TEXT;
    row.text = b;
    plan.push_back(row);
  endfunction

  function automatic void add_known(input logic [7:0] b, input logic [7:0] chr,
                                    input logic [7:0] reps);
    plan_row_t row;
    row           = '0;
    row.kind      = ROW_TEXT;
    row.text      = b;
    row.known     = 1'b1;
    row.want.chr  = chr;
    row.want.reps = reps;
    plan.push_back(row);
  endfunction

  // Offer one byte and wait for the transaction. Valid stays high afterwards so
  // a zero gap gives back-to-back transactions; the next call or a drain drops it.
  task automatic send_byte(input logic [7:0] b, input bit known, input run_t fixed);
    int   gap;
    run_t predicted;
    gap = draw_gap(1'b0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    predicted = expand_byte(b);
    pending_runs.push_back(known ? fixed : predicted);
    bytes_sent++;
  endtask

  // Drop valid and wait until every expected run has come back.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_runs.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    store_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Load a full register set for one random phase. The first phases pin the
  // extremes; later ones draw the rest, phase 5 held in list mode, a zero tab width now and then.
  task automatic configure_phase(input int ph);
    logic [7:0]   tc;
    logic [7:0]   tw;
    logic         lm;
    logic [255:0] map;
    int           thin;
    tc   = 8'($urandom_range(0, 255));
    tw   = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    lm   = 1'($urandom_range(0, 1));
    thin = $urandom_range(1, 5);
    case (ph)
      0: begin tc = 8'h09; lm = 1'b0; tw = 8'd1;   end
      1: begin tc = 8'h00; lm = 1'b0; tw = 8'd255; end
      2: begin tc = 8'hFF; lm = 1'b1; end
      3: begin tc = 8'h09; lm = 1'b1; thin = 0; end
      5: lm = 1'b1;
      default: ;
    endcase
    map = {rand_word(thin), rand_word(thin), rand_word(thin), rand_word(thin)};
    if (ph == 2) map = '0;
    write_reg(REG_TAB_CHARACTER, with_junk({56'd0, tc}, 64'hFF));
    write_reg(REG_LIST_MODE,     with_junk({63'd0, lm}, 64'h1));
    write_reg(REG_TAB_WIDTH,     with_junk({56'd0, tw}, 64'hFF));
    write_reg(REG_STOPS_0, map[63:0]);
    write_reg(REG_STOPS_1, map[127:64]);
    write_reg(REG_STOPS_2, map[191:128]);
    write_reg(REG_STOPS_3, map[255:192]);
    if ($urandom_range(0, 1) == 1) write_reg(REG_NONE, {$urandom, $urandom});
    tab_pct     = $urandom_range(15, 50);
    nl_permille = $urandom_range(2, 120);
  endtask

  // Output side: hold ready low for a drawn number of cycles after each
  // transaction, and check every accepted run against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_gap = draw_gap(1'b1);
    end else if (out_valid && out_ready) begin
      runs_checked++;
      if (pending_runs.size() == 0) begin
        miss_count++;
        if (miss_count <= 10)
          $display("[%0t] run %02h x%0d with nothing pending", $realtime, out_byte,
                   repeat_count);
      end else begin
        got_want = pending_runs.pop_front();
        if (out_byte !== got_want.chr || repeat_count !== got_want.reps) begin
          miss_count++;
          if (miss_count <= 10)
            $display("[%0t] run mismatch: expected %02h x%0d, got %02h x%0d", $realtime,
                     got_want.chr, got_want.reps, out_byte, repeat_count);
        end
      end
      sink_gap = draw_gap(1'b1);
      if (sink_gap != 0) out_ready <= 1'b0;
    end else if (!out_ready) begin
      if (sink_gap <= 1) out_ready <= 1'b1;
      else sink_gap--;
    end
  end

  initial begin : stimulus
    run_t none;
    none = '0;
    reset_model();

    // Directed plan, starting from the reset settings: tab 0x09, width 8.
    add_known(8'h41, 8'h41, 8'd1);
    add_known(8'h09, SPACE_BYTE, 8'd6);    // column 2 to the stop at 8
    add_known(8'h09, SPACE_BYTE, 8'd8);    // already on a stop: a full interval
    add_known(NEWLINE_BYTE, NEWLINE_BYTE, 8'd1);
    add_known(8'h09, SPACE_BYTE, 8'd7);
    add_known(8'h00, 8'h00, 8'd1);
    add_known(8'hFF, 8'hFF, 8'd1);
    add_known(NEWLINE_BYTE, NEWLINE_BYTE, 8'd1);
    // zero width behaves as width one; the unmapped index must not land anywhere
    add_write(REG_TAB_WIDTH, 64'd0);
    add_write(REG_NONE, '1);
    add_known(8'h09, SPACE_BYTE, 8'd1);
    add_write(REG_TAB_WIDTH, 64'd255);
    add_known(8'h09, SPACE_BYTE, 8'd253);
    add_known(8'h09, SPACE_BYTE, 8'd255);  // widest possible run
    add_known(NEWLINE_BYTE, NEWLINE_BYTE, 8'd1);
    // newline configured as the tab byte still acts as a newline
    add_write(REG_TAB_CHARACTER, {56'd0, NEWLINE_BYTE});
    add_known(NEWLINE_BYTE, NEWLINE_BYTE, 8'd1);
    add_known(8'h09, 8'h09, 8'd1);
    // stop list: stops at columns 0, 5 and 255 only
    add_write(REG_TAB_CHARACTER, 64'hFF);
    add_write(REG_LIST_MODE, 64'd1);
    add_write(REG_STOPS_0, 64'h21);
    add_write(REG_STOPS_3, 64'h8000_0000_0000_0000);
    add_known(8'hFF, SPACE_BYTE, 8'd3);
    add_known(8'hFF, SPACE_BYTE, 8'd250);  // reach the last column of the map
    add_known(8'hFF, SPACE_BYTE, 8'd1);    // no stop left past column 255
    add_text(8'h7F);
    add_known(NEWLINE_BYTE, NEWLINE_BYTE, 8'd1);
    add_known(8'hFF, SPACE_BYTE, 8'd4);
    add_write(REG_STOPS_1, '1);
    add_write(REG_STOPS_2, '1);
    add_text(8'hFF);
    add_text(8'h80);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the plan; hold off every register write until the block is idle.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain_pipeline();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_byte(plan[i].text, plan[i].known, plan[i].want);
      end
    end

    // Random phases, each under fresh settings.
    for (int ph = 0; ph < 10; ph++) begin
      drain_pipeline();
      configure_phase(ph);
      repeat (160) send_byte(pick_text(), 1'b0, none);
      if (ph == 4) begin
        // Push the column into saturation: wide tabs and no newline. The
        // following phase is in list mode and starts at the clipped column.
        drain_pipeline();
        write_reg(REG_TAB_CHARACTER, 64'h09);
        write_reg(REG_LIST_MODE, 64'd0);
        write_reg(REG_TAB_WIDTH, 64'($urandom_range(240, 255)));
        tab_pct     = 97;
        nl_permille = 0;
        repeat (330) send_byte(pick_text(), 1'b0, none);
      end
    end

    drain_pipeline();
    // Leave room for any stray run after the last expected one.
    repeat (48) @(posedge clk);

    $display("Sent %0d bytes, checked %0d runs, %0d failures.", bytes_sent, runs_checked,
             miss_count);
    $display("Tabs expanded: %0d on a uniform grid, %0d from the stop list; %0d clipped moves.",
             tabs_uniform, tabs_list, sat_hits);
    if (miss_count == 0 && pending_runs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
